@@ rtl/stid_pkg.sv @@
// Package for the sorted table block: sizes, operation and status codes,
// controller states and the command/status structs between control and datapath.
// Depends on nothing.
`default_nettype none
package stid_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_EVAL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;        // latch a new operation
    logic       rd_en;       // read the entry picked by the scan index
    logic       ins_shift;   // move the read entry up one slot, step down
    logic       ins_place;   // write the value at the index, bump the count
    logic       del_step;    // match or move the read entry down, step up
    logic       del_finish;  // drop the count if a match was found
    logic       respond;     // present a result word
    logic [1:0] resp_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_delete;
    logic full;
    logic idx_zero;
    logic at_end;
    logic greater;
    logic found;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/stid_ctrl.sv @@
// Controller state machine for the sorted table: sequences the scan over
// the table one entry at a time. Depends on stid_pkg.
`default_nettype none
module stid_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire stid_pkg::stat_t  stat,
  output stid_pkg::cmd_t        cmd
);
  import stid_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.resp_status = STATUS_DONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (!stat.is_delete) begin
          if (stat.full) begin
            cmd.respond     = 1'b1;
            cmd.resp_status = STATUS_FULL;
            state_next      = S_IDLE;
          end else if (stat.idx_zero) begin
            cmd.ins_place = 1'b1;
            cmd.respond   = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            state_next = S_EVAL;
          end
        end else begin
          if (stat.at_end) begin
            cmd.del_finish  = 1'b1;
            cmd.respond     = 1'b1;
            cmd.resp_status = stat.found ? STATUS_DONE : STATUS_MISSING;
            state_next      = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        state_next = S_TEST;
        if (!stat.is_delete) begin
          if (stat.greater) begin
            cmd.ins_shift = 1'b1;
          end else begin
            cmd.ins_place = 1'b1;
            cmd.respond   = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.del_step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/stid_dp.sv @@
// Datapath for the sorted table: table memory, entry count, scan index,
// match flag and the result registers. Depends on stid_pkg.
`default_nettype none
module stid_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               kind,
  input  wire logic signed [31:0] value,
  input  wire stid_pkg::cmd_t     cmd,
  output stid_pkg::stat_t         stat,
  output logic                    done,
  output logic [1:0]              status,
  output logic [4:0]              entry_count
);
  import stid_pkg::*;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic               op_kind;
  logic signed [31:0] op_value;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic               found;

  logic [CNT_W-1:0]   idx_dec;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_data;
  logic               wr_en;

  assign idx_dec = idx - CNT_W'(1);
  assign rd_addr = (op_kind == KIND_INSERT) ? idx_dec[IDX_W-1:0] : idx[IDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[IDX_W-1:0];
    wr_data = op_value;
    if (cmd.ins_shift) begin
      wr_en   = 1'b1;
      wr_data = rd_data;
    end else if (cmd.ins_place) begin
      wr_en = 1'b1;
    end else if (cmd.del_step && found) begin
      wr_en   = 1'b1;
      wr_addr = idx_dec[IDX_W-1:0];
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind  <= kind;
      op_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      idx    <= '0;
      found  <= 1'b0;
      done   <= 1'b0;
      status <= STATUS_DONE;
    end else begin
      done <= cmd.respond;
      if (cmd.respond) begin
        status <= cmd.resp_status;
      end
      if (cmd.load) begin
        found <= 1'b0;
        idx   <= (kind == KIND_INSERT) ? count : '0;
      end
      if (cmd.ins_shift) begin
        idx <= idx_dec;
      end
      if (cmd.ins_place) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.del_step) begin
        idx <= idx + CNT_W'(1);
        if (!found && rd_data == op_value) begin
          found <= 1'b1;
        end
      end
      if (cmd.del_finish && found) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign stat.is_delete = (op_kind == KIND_DELETE);
  assign stat.full      = (count == CNT_W'(DEPTH));
  assign stat.idx_zero  = (idx == '0);
  assign stat.at_end    = (idx == count);
  assign stat.greater   = (rd_data > op_value);
  assign stat.found     = found;

  assign entry_count = 5'(count);

endmodule
`default_nettype wire

@@ rtl/sorted_table_insert_delete_top.sv @@
// Sorted table top level: ascending table of signed words with insert/delete.
// Insert walks down from the top entry, moving each larger entry up one slot, then
// writes the value; delete walks up from the front and moves each later entry down
// once a match is found. Insert into a full table answers without a scan.
// Throughput: one operation at a time; each entry scanned takes one registered read
// of the table memory, then one compare and write.
// Reset (rst, synchronous) empties the table; the receiver cannot stall results.
`default_nettype none
module sorted_table_insert_delete_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               kind,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic [1:0]              status,
  output logic [4:0]              entry_count
);
  import stid_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller: accept a word while idle, then walk the table.
  stid_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath: hold the table and count, drive the result word for one cycle.
  stid_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .value       (value),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule
`default_nettype wire

@@ sim/sorted_table_insert_delete_top_tb.sv @@
// Self-checking testbench for sorted_table_insert_delete_top: drives insert and delete
// words, keeps its own sorted copy of the table to predict status and count.
// Depends on rtl/stid_pkg.sv and rtl/sorted_table_insert_delete_top.sv.
`default_nettype none
module sorted_table_insert_delete_top_tb;
  import stid_pkg::*;

  // Run sizing. The longest operation is a delete over a full table.
  localparam int NUM_RANDOM   = 1100;
  localparam int DRAIN_CYCLES = 2 + 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SHOW_LIMIT   = 10;
  localparam int NUM_DIRECTED = 25;

  // One result word as the block reports it.
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] count;
  } result_word_t;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic         kind;
    logic [31:0]  value;
    logic         typed;
    result_word_t want;
  } directed_row_t;

  localparam result_word_t NO_WANT = '0;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               kind;
  logic signed [31:0] value;
  logic               done;
  logic [1:0]         status;
  logic [4:0]         entry_count;

  sorted_table_insert_delete_top uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .value       (value),
    .done        (done),
    .status      (status),
    .entry_count (entry_count)
  );

  // Shadow of the block's table, kept in ascending signed order.
  logic signed [31:0] shadow_entries [$];
  // Result words still owed by the block, oldest first.
  result_word_t       owed_results [$];

  int cycle_count;
  int fault_count;
  int inserts_sent;
  int deletes_sent;
  int done_seen;
  int full_seen;
  int missing_seen;
  int burst_left;

  directed_row_t directed_rows [NUM_DIRECTED];

  // Clock: 10 time units per period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the shadow table and return the word the block must give.
  function automatic result_word_t apply_sorted_op(input logic op,
                                                   input logic signed [31:0] v);
    result_word_t res;
    int           pos;
    res.status = STATUS_DONE;
    if (op == KIND_INSERT) begin
      if (shadow_entries.size() >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        // Place the value after every entry that is not larger than it.
        pos = shadow_entries.size();
        for (int i = 0; i < shadow_entries.size(); i++) begin
          if (shadow_entries[i] > v) begin
            pos = i;
            break;
          end
        end
        shadow_entries.insert(pos, v);
      end
    end else begin
      pos = -1;
      for (int i = 0; i < shadow_entries.size(); i++) begin
        if (shadow_entries[i] == v) begin
          pos = i;
          break;
        end
      end
      if (pos < 0) res.status = STATUS_MISSING;
      else shadow_entries.delete(pos);
    end
    res.count = 5'(shadow_entries.size());
    return res;
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= SHOW_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Sender pacing: bursts of back-to-back words, random gaps in between.
  // Scramble the idle data so the block is seen to ignore it.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 3))
        0:       gap = $urandom_range(1, 2 * DEPTH + 6);
        default: gap = $urandom_range(1, 4);
      endcase
      start <= 1'b0;
      kind  <= 1'($urandom);
      value <= $urandom;
      repeat (gap) @(posedge clk);
      // Mostly short bursts, now and then a long stretch with no idling.
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 150);
      else burst_left = $urandom_range(0, 12);
    end
  endtask

  // Offer one word and hold it until the block takes it, then log what it owes.
  task automatic send_word(input logic op, input logic [31:0] v, input logic typed,
                           input result_word_t want);
    result_word_t predicted;
    pace_sender();
    start <= 1'b1;
    kind  <= op;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_sorted_op(op, v);
    owed_results.push_back(typed ? want : predicted);
    if (op == KIND_INSERT) inserts_sent++;
    else deletes_sent++;
  endtask

  // Random operand: duplicates from a narrow pool, extremes, or any 32-bit value.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($signed($urandom_range(0, 8)) - 4);
      4, 5: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h8000_0001;
          2:       return 32'h7FFF_FFFF;
          3:       return 32'h7FFF_FFFE;
          4:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Result checker: the receiver never stalls, so take every strobe as it comes.
  always @(posedge clk) begin
    result_word_t want;
    if (!rst) begin
      if ($isunknown(done)) begin
        report_fault("done strobe is unknown");
      end else if (done) begin
        if (owed_results.size() == 0) begin
          report_fault($sformatf("result word with nothing owed: status %0d count %0d",
                                 status, entry_count));
        end else begin
          want = owed_results.pop_front();
          if (status !== want.status)
            report_fault($sformatf("status expected %0d got %0d", want.status, status));
          if (entry_count !== want.count)
            report_fault($sformatf("entry_count expected %0d got %0d",
                                   want.count, entry_count));
          case (status)
            STATUS_FULL:    full_seen++;
            STATUS_MISSING: missing_seen++;
            default:        done_seen++;
          endcase
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycle_count,
               owed_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int insert_pct;
    logic op;
    logic [31:0] operand;

    // Hold every input at a known value from time zero.
    rst          = 1'b1;
    start        = 1'b0;
    kind         = KIND_INSERT;
    value        = '0;
    cycle_count  = 0;
    fault_count  = 0;
    inserts_sent = 0;
    deletes_sent = 0;
    done_seen    = 0;
    full_seen    = 0;
    missing_seen = 0;
    burst_left   = 0;
    insert_pct   = 50;

    // Directed words: empty-table delete, extremes, duplicates, fill to capacity,
    // insert into a full table, removal of the largest and smallest, missing delete.
    directed_rows = '{
      '{KIND_DELETE, 32'h0000_0000, 1'b1, '{STATUS_MISSING, 5'd0}},
      '{KIND_INSERT, 32'h7FFF_FFFF, 1'b1, '{STATUS_DONE,    5'd1}},
      '{KIND_INSERT, 32'h8000_0000, 1'b1, '{STATUS_DONE,    5'd2}},
      '{KIND_INSERT, 32'h0000_0000, 1'b1, '{STATUS_DONE,    5'd3}},
      '{KIND_INSERT, 32'hFFFF_FFFF, 1'b1, '{STATUS_DONE,    5'd4}},
      '{KIND_INSERT, 32'h0000_0000, 1'b1, '{STATUS_DONE,    5'd5}},
      '{KIND_DELETE, 32'h0000_0005, 1'b1, '{STATUS_MISSING, 5'd5}},
      '{KIND_DELETE, 32'h0000_0000, 1'b1, '{STATUS_DONE,    5'd4}},
      '{KIND_INSERT, 32'h0000_0001, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'h7FFF_FFFF, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'h8000_0000, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'h5555_5555, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'hAAAA_AAAA, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'h0000_0002, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'hFFFF_FFFE, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'h4000_0000, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'hC000_0000, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'h0000_0000, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'h7FFF_FFFE, 1'b0, NO_WANT},
      '{KIND_INSERT, 32'h8000_0001, 1'b1, '{STATUS_DONE,    5'd16}},
      '{KIND_INSERT, 32'h0000_0005, 1'b1, '{STATUS_FULL,    5'd16}},
      '{KIND_DELETE, 32'h7FFF_FFFF, 1'b1, '{STATUS_DONE,    5'd15}},
      '{KIND_DELETE, 32'h8000_0000, 1'b1, '{STATUS_DONE,    5'd14}},
      '{KIND_INSERT, 32'h8000_0000, 1'b0, NO_WANT},
      '{KIND_DELETE, 32'h1234_5678, 1'b1, '{STATUS_MISSING, 5'd15}}
    };

    // Hold reset, then release it once.
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table.
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_word(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].want);

    // Random words. Swing the insert share every few dozen words so the table
    // drains to empty and fills to capacity again and again.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 48 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 20;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      op = ($urandom_range(1, 100) <= insert_pct) ? KIND_INSERT : KIND_DELETE;
      // Mostly delete a value that is held, so deletes reach every slot.
      if (op == KIND_DELETE && shadow_entries.size() != 0 && $urandom_range(0, 9) < 7)
        operand = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
      else
        operand = pick_operand();
      send_word(op, operand, 1'b0, NO_WANT);
    end

    // Drop start, wait for every owed word, then watch for strays.
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d inserts and %0d deletes in %0d cycles.", inserts_sent,
             deletes_sent, cycle_count);
    $display("Results: %0d done, %0d table full, %0d not found; %0d mismatches.",
             done_seen, full_seen, missing_seen, fault_count);
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
